@@ rtl/vsb_pkg.sv @@
// Shared types and constants for the vertex skinning blend block.
// Holds the token that travels along the row of multiply-accumulate cells.
// No dependencies.
`timescale 1ns / 1ps

package vsb_pkg;

    // Words of one row-major 3x4 bone matrix.
    localparam int WORDS_PER_BONE = 12;

    // Width of the running position sum (floor-shifted products plus offset).
    localparam int PSW = 52;
    // Width of the running normal sum (exact products).
    localparam int NSW = 50;
    // Width of the blended accumulators.
    localparam int ACW = 52;

    // Item that moves one cell to the right every cycle.
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [1:0]            row;
        logic [15:0]           weight;
        logic signed [PSW-1:0] psum;
        logic signed [NSW-1:0] nsum;
    } t_tok;

endpackage

@@ rtl/vsb_ram.sv @@
// Generic single-write, single-read memory with a registered read port.
// Holds the bone matrix table. No dependencies.
`timescale 1ns / 1ps

module vsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 3072
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/vsb_cell.sv @@
// One multiply-accumulate cell of the matrix row chain.
// Adds the current matrix word times its own operand to the passing sums.
// Depends on vsb_pkg.
`timescale 1ns / 1ps

module vsb_cell import vsb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_tok               i_tok,
    input  logic signed [31:0] i_word,
    input  logic signed [31:0] i_pos_op,
    input  logic signed [15:0] i_nrm_op,
    output t_tok               o_tok
);

    logic signed [63:0] w_pprod;
    logic signed [47:0] w_nprod;
    t_tok               n_tok;
    t_tok               r_tok;

    // Position term is floored to Q16.16, normal term is kept exact.
    always_comb begin
        w_pprod     = i_word * i_pos_op;
        w_nprod     = i_word * i_nrm_op;
        n_tok       = i_tok;
        n_tok.psum  = i_tok.psum + PSW'(w_pprod >>> 16);
        n_tok.nsum  = i_tok.nsum + NSW'(w_nprod);
    end

    // Hand the item to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ rtl/vsb_norm.sv @@
// Normal renormalization unit: scaling search, squared length, square root
// and one shared divider; root and divider step one bit per cycle. Depends on vsb_pkg.
`timescale 1ns / 1ps

module vsb_norm import vsb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [ACW-1:0] i_acc [3],
    output logic signed [15:0]    o_nrm [3],
    output logic                  o_done
);

    typedef enum logic [5:0] {
        N_IDLE  = 6'b000001,
        N_SHIFT = 6'b000010,
        N_SQ    = 6'b000100,
        N_SQRT  = 6'b001000,
        N_DSET  = 6'b010000,
        N_DIV   = 6'b100000
    } t_nstate;

    t_nstate            r_state;
    logic [ACW-1:0]     r_mag [3];
    logic [2:0]         r_neg;
    logic [ACW-1:0]     r_mx;
    logic [1:0]         r_idx;
    logic [61:0]        r_sum;
    logic [61:0]        r_v;
    logic [63:0]        r_res;
    logic [4:0]         r_bit;
    logic [31:0]        r_len;
    logic [32:0]        r_rem;
    logic [15:0]        r_lo;
    logic [15:0]        r_q;
    logic [4:0]         r_dcnt;
    logic signed [15:0] r_nrm [3];
    logic               r_done;

    logic [ACW-1:0]     w_mag [3];
    logic [ACW-1:0]     w_mx;
    logic [29:0]        w_sqin;
    logic [63:0]        w_sbit;
    logic [63:0]        w_trial_sq;
    logic [45:0]        w_num;
    logic [32:0]        w_trial;
    logic [14:0]        w_qcap;

    // Magnitudes and their maximum at start.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = i_acc[i][ACW-1] ? ACW'(-i_acc[i]) : ACW'(i_acc[i]);
        end
        w_mx = w_mag[0];
        if (w_mag[1] > w_mx) w_mx = w_mag[1];
        if (w_mag[2] > w_mx) w_mx = w_mag[2];
    end

    // Datapath helpers for the square, root and division steps.
    always_comb begin
        w_sqin     = r_mag[r_idx][29:0];
        w_sbit     = 64'd1 << {r_bit, 1'b0};
        w_trial_sq = r_res + w_sbit;
        w_num      = {2'b00, r_mag[r_idx][29:0], 14'd0} + 46'(r_len >> 1);
        w_trial    = {r_rem[31:0], r_lo[15]};
        w_qcap     = (r_q > 16'd16384) ? 15'd16384 : r_q[14:0];
    end

    // Sequencer of the renormalization steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= w_mag[i];
                            r_neg[i] <= i_acc[i][ACW-1];
                        end
                        r_mx <= w_mx;
                        if (w_mx == '0) begin
                            for (int i = 0; i < 3; i++) r_nrm[i] <= 16'sd0;
                            r_done <= 1'b1;
                        end else begin
                            r_state <= N_SHIFT;
                        end
                    end
                end
                N_SHIFT: begin
                    // One binary place per cycle until the largest is in [2^29, 2^30).
                    if (r_mx >= (ACW'(1) << 30)) begin
                        r_mx <= r_mx >> 1;
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else if (r_mx < (ACW'(1) << 29)) begin
                        r_mx <= r_mx << 1;
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                    end else begin
                        r_idx   <= 2'd0;
                        r_sum   <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    // One squared component per cycle on a shared multiplier.
                    r_sum <= r_sum + 62'(60'(w_sqin) * 60'(w_sqin));
                    if (r_idx == 2'd2) begin
                        r_v     <= r_sum + 62'(60'(w_sqin) * 60'(w_sqin));
                        r_res   <= '0;
                        r_bit   <= 5'd31;
                        r_state <= N_SQRT;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                N_SQRT: begin
                    // Digit-by-digit integer square root, one result bit per cycle.
                    if ({2'b00, r_v} >= w_trial_sq) begin
                        r_v   <= 62'({2'b00, r_v} - w_trial_sq);
                        r_res <= (r_res >> 1) + w_sbit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    if (r_bit == 5'd0) begin
                        r_idx   <= 2'd0;
                        r_state <= N_DSET;
                    end else begin
                        r_bit <= r_bit - 5'd1;
                    end
                    if (r_bit == 5'd0) begin
                        if ({2'b00, r_v} >= w_trial_sq) begin
                            r_len <= 32'((r_res >> 1) + w_sbit);
                        end else begin
                            r_len <= 32'(r_res >> 1);
                        end
                    end
                end
                N_DSET: begin
                    // Rounded numerator; the quotient fits in sixteen bits.
                    r_rem   <= 33'(w_num[45:16]);
                    r_lo    <= w_num[15:0];
                    r_q     <= '0;
                    r_dcnt  <= 5'd16;
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    if (r_dcnt != 5'd0) begin
                        // Restoring division, one quotient bit per cycle.
                        if (w_trial >= {1'b0, r_len}) begin
                            r_rem <= w_trial - {1'b0, r_len};
                            r_q   <= {r_q[14:0], 1'b1};
                        end else begin
                            r_rem <= w_trial;
                            r_q   <= {r_q[14:0], 1'b0};
                        end
                        r_lo   <= r_lo << 1;
                        r_dcnt <= r_dcnt - 5'd1;
                    end else begin
                        r_nrm[r_idx] <= r_neg[r_idx] ? -$signed({1'b0, w_qcap})
                                                     : $signed({1'b0, w_qcap});
                        if (r_idx == 2'd2) begin
                            r_done  <= 1'b1;
                            r_state <= N_IDLE;
                        end else begin
                            r_idx   <= r_idx + 2'd1;
                            r_state <= N_DSET;
                        end
                    end
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_nrm  = r_nrm;
    assign o_done = r_done;

endmodule

@@ rtl/vertex_skinning_blend.sv @@
// Linear blend skinning, four influences per vertex, one matrix word read per cycle.
// Load item: written into the table. Skin item: twelve words read per counting influence,
// skipped ones passed over, then cell row drain and renormalization. A vertex with no
// counting influence is passed on unchanged. One item at a time.
// Synchronous active-low reset clears control and bone_count; the table is not cleared.
// Depends on vsb_pkg, vsb_ram, vsb_cell and vsb_norm.
`timescale 1ns / 1ps

module vertex_skinning_blend import vsb_pkg::*; #(
    parameter int MAX_BONES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration: bone_count.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [8:0]   i_cfg_data,
    // Input items.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mat_addr[11:0], mat_value[43:12], pos_x[75:44], pos_y[107:76], pos_z[139:108],
    // nrm_x[155:140], nrm_y[171:156], nrm_z[187:172], bone_ids[219:188],
    // bone_weights[283:220], zero fill[287:284]
    input  logic [287:0] s_axis_tdata,
    // op
    input  logic         s_axis_tuser,
    // Result items.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_pos_x[31:0], out_pos_y[63:32], out_pos_z[95:64], out_nrm_x[111:96],
    // out_nrm_y[127:112], out_nrm_z[143:128]
    output logic [143:0] m_axis_tdata,
    // was_skinned
    output logic         m_axis_tuser
);

    localparam int TABLE_WORDS = MAX_BONES * WORDS_PER_BONE;
    localparam int AW          = $clog2(TABLE_WORDS);
    localparam logic [8:0]  MAXB = 9'(MAX_BONES);
    localparam logic [12:0] TBLW = 13'(TABLE_WORDS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_DRAIN = 5'b00100,
        S_NORM  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state              r_state;
    logic [8:0]          r_bone_count;
    logic signed [31:0]  r_pos [3];
    logic signed [15:0]  r_nrm [3];
    logic [31:0]         r_ids;
    logic [63:0]         r_wts;
    logic [3:0]          r_mask;
    logic [1:0]          r_k;
    logic [3:0]          r_word;
    logic                r_skinned;
    t_tok                r_launch;
    logic                r_wvalid;
    logic                r_wlast;
    logic [1:0]          r_wrow;
    logic signed [48:0]  r_wp;
    logic signed [50:0]  r_wn;
    logic signed [ACW-1:0] r_pacc [3];
    logic signed [ACW-1:0] r_nacc [3];
    logic                r_acc_last;
    logic                r_norm_start;
    logic                r_ovalid;
    logic [143:0]        r_odata;
    logic                r_ouser;

    logic [8:0]          w_limit;
    logic [3:0]          w_mask;
    logic                w_in_acc;
    logic [7:0]          w_id;
    logic [11:0]         w_base;
    logic [11:0]         w_addr;
    logic [3:0]          w_hi;
    logic [31:0]         w_rdata;
    t_tok                w_tok [5];
    logic signed [31:0]  w_pos_op [4];
    logic signed [15:0]  w_nrm_op [4];
    logic signed [31:0]  w_t32;
    logic signed [NSW-17:0] w_s16;
    logic signed [15:0]  w_nout [3];
    logic                w_norm_done;
    logic signed [31:0]  w_pout [3];
    logic signed [ACW-16:0] w_pshift;
    logic                w_out_load;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_limit       = (r_bone_count > MAXB) ? MAXB : r_bone_count;

    // Influences that count: nonzero weight and a valid bone.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_mask[k] = (s_axis_tdata[220 + 16*k +: 16] != 16'd0) &&
                        ({1'b0, s_axis_tdata[188 + 8*k +: 8]} < w_limit);
        end
    end

    // Read address of the current matrix word.
    always_comb begin
        w_id   = r_ids[8*r_k +: 8];
        w_base = ({4'd0, w_id} << 3) + ({4'd0, w_id} << 2);
        w_addr = w_base + {8'd0, r_word};
        w_hi   = r_mask >> r_k;
    end

    vsb_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_WORDS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && !s_axis_tuser && ({1'b0, s_axis_tdata[11:0]} < TBLW)),
        .i_waddr (s_axis_tdata[AW-1:0]),
        .i_wdata (s_axis_tdata[43:12]),
        .i_raddr (w_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Operands of the four cells: x, y, z and, for the offset column, a unit position factor and a zero normal factor.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_pos_op[c] = r_pos[c];
            w_nrm_op[c] = r_nrm[c];
        end
        w_pos_op[3] = 32'sh0001_0000;
        w_nrm_op[3] = 16'sd0;
    end

    assign w_tok[0] = r_launch;

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_cell
            vsb_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_tok    (w_tok[g]),
                .i_word   ($signed(w_rdata)),
                .i_pos_op (w_pos_op[g]),
                .i_nrm_op (w_nrm_op[g]),
                .o_tok    (w_tok[g+1])
            );
        end
    endgenerate

    // Saturated row result and floored normal term.
    always_comb begin
        if (w_tok[4].psum > PSW'(64'sh7FFF_FFFF)) begin
            w_t32 = 32'sh7FFF_FFFF;
        end else if (w_tok[4].psum < -PSW'(64'sh8000_0000)) begin
            w_t32 = -32'sh8000_0000;
        end else begin
            w_t32 = 32'(w_tok[4].psum);
        end
        w_s16 = (NSW-16)'(w_tok[4].nsum >>> 16);
    end

    // Final position rounding and saturation.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pshift = (ACW-15)'((r_pacc[i] + ACW'(16384)) >>> 15);
            if (w_pshift > (ACW-15)'(64'sh7FFF_FFFF)) begin
                w_pout[i] = 32'sh7FFF_FFFF;
            end else if (w_pshift < -(ACW-15)'(64'sh8000_0000)) begin
                w_pout[i] = -32'sh8000_0000;
            end else begin
                w_pout[i] = 32'(w_pshift);
            end
        end
    end

    vsb_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_norm_start),
        .i_acc   (r_nacc),
        .o_nrm   (w_nout),
        .o_done  (w_norm_done)
    );

    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bone_count <= 9'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_bone_count <= i_cfg_data;
        end
    end

    // Sequencer: accept, issue matrix reads, drain, renormalize, output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_launch.valid <= 1'b0;
            r_norm_start   <= 1'b0;
        end else begin
            r_launch.valid <= 1'b0;
            r_norm_start   <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && s_axis_tuser) begin
                        for (int i = 0; i < 3; i++) begin
                            r_pos[i] <= $signed(s_axis_tdata[44 + 32*i +: 32]);
                            r_nrm[i] <= $signed(s_axis_tdata[140 + 16*i +: 16]);
                        end
                        r_ids     <= s_axis_tdata[219:188];
                        r_wts     <= s_axis_tdata[283:220];
                        r_mask    <= w_mask;
                        r_k       <= 2'd0;
                        r_word    <= 4'd0;
                        r_skinned <= (w_mask != 4'd0);
                        r_state   <= (w_mask != 4'd0) ? S_ISSUE : S_OUT;
                    end
                end
                S_ISSUE: begin
                    if (r_mask[r_k]) begin
                        // Start a row item when its first column is read.
                        if (r_word[1:0] == 2'd0) begin
                            r_launch.valid  <= 1'b1;
                            r_launch.last   <= (r_word[3:2] == 2'd2) && (w_hi[3:1] == 3'd0);
                            r_launch.row    <= r_word[3:2];
                            r_launch.weight <= r_wts[16*r_k +: 16];
                            r_launch.psum   <= '0;
                            r_launch.nsum   <= '0;
                        end
                    end
                    if (!r_mask[r_k] || r_word == 4'(WORDS_PER_BONE - 1)) begin
                        r_word <= 4'd0;
                        r_k    <= r_k + 2'd1;
                        if (r_k == 2'd3) r_state <= S_DRAIN;
                    end else begin
                        r_word <= r_word + 4'd1;
                    end
                end
                S_DRAIN: begin
                    if (r_acc_last) begin
                        r_norm_start <= 1'b1;
                        r_state      <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (w_norm_done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Weighting stage after the cell row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= 1'b0;
        end else begin
            r_wvalid <= w_tok[4].valid;
        end
        r_wlast <= w_tok[4].last;
        r_wrow  <= w_tok[4].row;
        r_wp    <= w_t32 * $signed({1'b0, w_tok[4].weight});
        r_wn    <= w_s16 * $signed({1'b0, w_tok[4].weight});
    end

    // Blend accumulators, cleared whenever an input item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_last <= 1'b0;
        end else begin
            r_acc_last <= r_wvalid && r_wlast;
        end
        if (w_in_acc) begin
            for (int i = 0; i < 3; i++) begin
                r_pacc[i] <= '0;
                r_nacc[i] <= '0;
            end
        end else if (r_wvalid) begin
            r_pacc[r_wrow] <= r_pacc[r_wrow] + ACW'(r_wp);
            r_nacc[r_wrow] <= r_nacc[r_wrow] + ACW'(r_wn);
        end
    end

    // Output register; a held result does not block the next item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (w_out_load) begin
            r_ouser <= r_skinned;
            if (r_skinned) begin
                r_odata <= {w_nout[2], w_nout[1], w_nout[0],
                            w_pout[2], w_pout[1], w_pout[0]};
            end else begin
                r_odata <= {r_nrm[2], r_nrm[1], r_nrm[0],
                            r_pos[2], r_pos[1], r_pos[0]};
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

`ifndef SYNTHESIS
    a_last_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_last |-> r_state == S_DRAIN)
        else $error("last row accumulated outside drain");
    a_norm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_norm_done |-> r_state == S_NORM)
        else $error("normalizer finished while not awaited");
    a_launch_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch.valid |-> $past(r_state) == S_ISSUE)
        else $error("row item launched outside issue");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wvalid |-> r_wrow != 2'd3)
        else $error("row index out of range");
`endif

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the vertex skinning blend block.
// A scoreboard class predicts every vertex result from the loaded bone table and
// bone_count; plain tasks drive the item stream and the configuration channel.
`timescale 1ns / 1ps

// Expected result of one skin item.
typedef struct {
    logic [143:0] data;
    logic         skinned;
} t_vertex_result;

class skin_scoreboard;
    logic [31:0]    bone_tbl [3072];
    bit             word_loaded [3072];
    int unsigned    bone_count;
    t_vertex_result pending_q [$];
    int             errors;

    function new();
        bone_count = 0;
        errors = 0;
        foreach (word_loaded[i]) word_loaded[i] = 0;
    endfunction

    function void set_bone_count(logic [8:0] v);
        bone_count = 32'(v);
    endfunction

    function int unsigned bone_limit();
        return (bone_count < 256) ? bone_count : 256;
    endfunction

    // A bone may be referenced only once all twelve of its words hold data.
    function bit bone_ready(int unsigned b);
        for (int i = 0; i < 12; i++)
            if (!word_loaded[b * 12 + i]) return 0;
        return 1;
    endfunction

    function longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v = v - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Scale the blended normal into [2^29, 2^30) and divide by its length.
    function void unit_normal(input longint acc [3], output longint outn [3]);
        longint unsigned mag [3];
        longint unsigned mx, len, q;
        bit neg [3];
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = acc[i] < 0;
            mag[i] = neg[i] ? -acc[i] : acc[i];
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) outn[i] = 0;
            return;
        end
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        len = isqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 16384 + (len >> 1)) / len;
            if (q > 16384) q = 16384;
            outn[i] = neg[i] ? -longint'(q) : longint'(q);
        end
    endfunction

    // Note one accepted input item: load a table word or predict a vertex.
    function void note_input(logic op, logic [287:0] d);
        longint p [3], n [3], pacc [3], nacc [3], nout [3], m [4];
        longint t, s, w, v;
        int unsigned b, a;
        bit any;
        t_vertex_result r;
        if (op == 1'b0) begin
            a = d[11:0];
            if (a < 3072) begin
                bone_tbl[a] = d[43:12];
                word_loaded[a] = 1;
            end
            return;
        end
        any = 0;
        for (int i = 0; i < 3; i++) begin
            p[i] = $signed(d[44 + 32 * i +: 32]);
            n[i] = $signed(d[140 + 16 * i +: 16]);
            pacc[i] = 0;
            nacc[i] = 0;
        end
        for (int k = 0; k < 4; k++) begin
            b = d[188 + 8 * k +: 8];
            w = d[220 + 16 * k +: 16];
            if (w == 0 || b >= bone_limit()) continue;
            for (int row = 0; row < 3; row++) begin
                for (int c = 0; c < 4; c++)
                    m[c] = $signed(bone_tbl[b * 12 + row * 4 + c]);
                t = ((m[0] * p[0]) >>> 16) + ((m[1] * p[1]) >>> 16)
                  + ((m[2] * p[2]) >>> 16) + m[3];
                s = m[0] * n[0] + m[1] * n[1] + m[2] * n[2];
                pacc[row] += sat32(t) * w;
                nacc[row] += (s >>> 16) * w;
            end
            any = 1;
        end
        if (!any) begin
            r.data = {d[187:140], d[139:44]};
            r.skinned = 1'b0;
        end else begin
            unit_normal(nacc, nout);
            for (int i = 0; i < 3; i++) begin
                v = sat32((pacc[i] + 16384) >>> 15);
                r.data[32 * i +: 32] = v[31:0];
                r.data[96 + 16 * i +: 16] = nout[i][15:0];
            end
            r.skinned = 1'b1;
        end
        pending_q = {pending_q, r};
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(logic [143:0] d, logic skinned);
        t_vertex_result e;
        int off [7] = '{0, 32, 64, 96, 112, 128, 144};
        string names [6] = '{"pos_x", "pos_y", "pos_z", "nrm_x", "nrm_y", "nrm_z"};
        logic [143:0] mask;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result %h / %b", $time, d, skinned);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        for (int i = 0; i < 6; i++) begin
            mask = (144'd1 << (off[i + 1] - off[i])) - 1;
            if (((e.data >> off[i]) & mask) !== ((d >> off[i]) & mask)) begin
                $display("%0t: %s expected %h actual %h", $time, names[i],
                         (e.data >> off[i]) & mask, (d >> off[i]) & mask);
                errors++;
            end
        end
        if (e.skinned !== skinned) begin
            $display("%0t: was_skinned expected %b actual %b", $time, e.skinned, skinned);
            errors++;
        end
    endfunction
endclass

module tb;
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [8:0]   i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tuser;

    skin_scoreboard sb = new();
    bit quiet = 0;
    int stall_left = 0;

    vertex_skinning_blend DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Result side: check accepted items and stall in random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Hand one item to the block, with an occasional idle burst before it.
    task automatic send_item(input logic op, input logic [287:0] d);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, d);
    endtask

    task automatic load_word(input int unsigned addr, input logic [31:0] value);
        send_item(1'b0, {244'd0, value, addr[11:0]});
    endtask

    function automatic logic [31:0] rand_mat_word(int c, bit wild);
        if (wild || $urandom_range(0, 7) == 0) return $urandom;
        if (c == 3) return $urandom_range(0, 1 << 25) - (1 << 24);
        return $urandom_range(0, 131072) - 65536;
    endfunction

    task automatic load_bone(input int unsigned b, input bit wild);
        for (int i = 0; i < 12; i++) load_word(b * 12 + i, rand_mat_word(i % 4, wild));
    endtask

    function automatic logic [287:0] skin_data(logic [31:0] px, py, pz,
                                               logic [15:0] nx, ny, nz,
                                               logic [31:0] ids, logic [63:0] wts);
        return {4'd0, wts, ids, nz, ny, nx, pz, py, px, 44'd0};
    endfunction

    // Random vertex; an influence that would read an unloaded bone gets weight 0.
    function automatic logic [287:0] rand_vertex();
        logic [31:0] p [3];
        logic [15:0] n [3];
        logic [31:0] ids;
        logic [63:0] wts;
        int unsigned b, w, left;
        left = 32768;
        for (int i = 0; i < 3; i++) begin
            p[i] = ($urandom_range(0, 3) == 0) ? $urandom
                                               : $urandom_range(0, 1 << 22) - (1 << 21);
            n[i] = 16'($urandom_range(0, 32768) - 16384);
        end
        if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) n[i] = '0;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 9))
                0: b = $urandom_range(0, 255);
                1: b = 255;
                default: b = $urandom_range(0, 39);
            endcase
            if ($urandom_range(0, 5) == 0) w = 0;
            else if ($urandom_range(0, 4) == 0) w = $urandom_range(0, 65535);
            else begin
                w = (k == 3) ? left : $urandom_range(0, left);
                left -= w;
            end
            if (w != 0 && b < sb.bone_limit() && !sb.bone_ready(b)) w = 0;
            ids[8 * k +: 8] = 8'(b);
            wts[16 * k +: 16] = 16'(w);
        end
        return skin_data(p[0], p[1], p[2], n[0], n[1], n[2], ids, wts);
    endfunction

    // Wait until all predictions are met and the block has gone quiet.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_bone_count(input logic [8:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_bone_count(v);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        #40_000_000;
        $display("[vertex_skinning_blend] ERROR");
        $finish;
    end

    initial begin
        logic [8:0] counts [8] = '{9'd3, 9'd16, 9'd256, 9'd511, 9'd0, 9'd40, 9'd257, 9'd1};
        logic [8:0] cnt;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With no valid bones every vertex passes through; far loads are dropped.
        send_item(1'b1, skin_data(32'h7fffffff, 32'h80000000, 32'h0, 16'h4000, 16'hc000,
                                  16'h0, 32'hffffffff, 64'hffffffffffffffff));
        load_word(3072, 32'hffffffff);
        load_word(4095, 32'h12345678);
        drain();

        write_bone_count(9'd256);
        // Bone 0 identity, bone 1 all zero, bone 255 arbitrary words.
        for (int i = 0; i < 12; i++) load_word(i, (i % 5 == 0) ? 32'h00010000 : 32'h0);
        for (int i = 0; i < 12; i++) load_word(12 + i, 32'h0);
        load_bone(255, 1);
        send_item(1'b1, skin_data(32'h00012345, 32'hfffe0000, 32'h7fffffff, 16'h4000,
                                  16'h0, 16'h0, 32'h00000000, 64'h0000000000008000));
        send_item(1'b1, skin_data(32'h00010000, 32'h00020000, 32'h00030000, 16'h2000,
                                  16'h2000, 16'h2000, 32'h01010101, 64'h2000200020002000));
        send_item(1'b1, skin_data(32'h80000000, 32'h80000000, 32'h80000000, 16'hc000,
                                  16'hc000, 16'hc000, 32'hffffffff, 64'hffffffffffffffff));
        send_item(1'b1, skin_data(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h4000,
                                  16'h4000, 16'h4000, 32'hff00ff00, 64'hffff0001ffff0001));
        send_item(1'b1, skin_data(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0,
                                  32'h00ff0100, 64'h0000000000000000));
        send_item(1'b1, skin_data(32'h7fffffff, 32'h80000000, 32'h1, 16'h4000,
                                  16'hc000, 16'h1, 32'h000000ff, 64'h000000000000ffff));
        drain();

        // Random phases over several bone counts; the last one runs without idling.
        for (int ph = 0; ph < 8; ph++) begin
            cnt = (ph == 5) ? 9'($urandom_range(0, 300)) : counts[ph];
            write_bone_count(cnt);
            if (ph == 7) quiet = 1;
            load_bone($urandom_range(0, 39), 0);
            load_bone($urandom_range(0, 39), $urandom_range(0, 3) == 0);
            for (int i = 0; i < 220; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 7) == 0)
                        load_word($urandom_range(3072, 4095), $urandom);
                    else
                        load_word($urandom_range(0, 479), rand_mat_word(i % 4, 0));
                end else begin
                    send_item(1'b1, rand_vertex());
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("[vertex_skinning_blend] OK");
        else
            $display("[vertex_skinning_blend] ERROR");
        $finish;
    end
endmodule
